/* hdl/lhc_pkg.sv */
// Shared types and constants for the latency histogram counter.
// No dependencies; imported by every module of the block.
package lhc_pkg;

    localparam int BUCKET_COUNT        = 10;
    localparam int BUCKET_W            = 4;
    localparam int DUR_W               = 64;
    localparam int FUNC_W              = 2;
    localparam int COUNT_WIDTH_DEFAULT = 64;
    localparam int BOUND_W             = 30;
    localparam int NUM_BOUNDS          = BUCKET_COUNT - 1;

    localparam logic [FUNC_W-1:0] FUNC_RECORD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [BUCKET_W-1:0] LAST_BUCKET = BUCKET_W'(BUCKET_COUNT - 1);

    // exclusive upper bounds of buckets 0..8, in ns
    localparam logic [BOUND_W-1:0] BOUNDS [NUM_BOUNDS] = '{
        30'd100, 30'd500, 30'd1000, 30'd10000, 30'd100000,
        30'd1000000, 30'd10000000, 30'd100000000, 30'd1000000000
    };

    typedef struct packed {
        logic                fire;
        logic [FUNC_W-1:0]   func;
        logic [BUCKET_W-1:0] bucket;
        logic                major;
    } lhc_cmd_t;

endpackage

/* hdl/latency_histogram_counter.sv */
// Top level of the two-class latency histogram counter.
// Depends on lhc_pkg, lhc_classify and lhc_counters.
//
// Each input transaction (record, read or clear) yields exactly one output
// transaction: the bucket compare and the counter update happen while it sits
// in the input register, and the result register then presents it. A new
// transaction is accepted every cycle as long as the output side is not
// stalled; throughput is one per clock, set by the single counter
// read-modify-write in the input stage. An output stall holds the result
// register, and the input stalls once the input register also holds a
// transaction. Counters reset to zero.
module latency_histogram_counter
    import lhc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [FUNC_W-1:0]      func,
    input  logic [DUR_W-1:0]       latency_ns,
    input  logic                   major_fault,
    input  logic [BUCKET_W-1:0]    bucket_select,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [BUCKET_W-1:0]    bucket_index,
    output logic [COUNT_WIDTH-1:0] minor_total,
    output logic [COUNT_WIDTH-1:0] major_total
);

    logic                   s1_valid_reg;
    logic [FUNC_W-1:0]      func_reg;
    logic [DUR_W-1:0]       dur_reg;
    logic                   major_reg;
    logic [BUCKET_W-1:0]    sel_reg;

    logic                   out_valid_reg;
    logic [BUCKET_W-1:0]    bucket_index_reg;
    logic [COUNT_WIDTH-1:0] minor_total_reg;
    logic [COUNT_WIDTH-1:0] major_total_reg;

    logic                   out_ready;
    logic                   s1_move;
    logic                   s1_ready;
    logic [BUCKET_W-1:0]    class_bucket;
    logic [BUCKET_W-1:0]    read_bucket;
    lhc_cmd_t               cmd;
    logic [BUCKET_W-1:0]    bucket_index_next;
    logic [COUNT_WIDTH-1:0] minor_total_next;
    logic [COUNT_WIDTH-1:0] major_total_next;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_move   = s1_valid_reg && out_ready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign in_stall  = !s1_ready;

    assign read_bucket = (sel_reg > LAST_BUCKET) ? LAST_BUCKET : sel_reg;

    lhc_classify u_classify
    (
        .latency_ns (dur_reg),
        .bucket     (class_bucket)
    );

    always_comb
    begin
        cmd.fire  = s1_move;
        cmd.func  = func_reg;
        cmd.major = major_reg;
        case (func_reg)
            FUNC_RECORD: cmd.bucket = class_bucket;
            FUNC_READ:   cmd.bucket = read_bucket;
            default:     cmd.bucket = '0;
        endcase
    end

    lhc_counters #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counters
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .bucket_index (bucket_index_next),
        .minor_total  (minor_total_next),
        .major_total  (major_total_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            func_reg  <= func;
            dur_reg   <= latency_ns;
            major_reg <= major_fault;
            sel_reg   <= bucket_select;
        end
        if (s1_move)
        begin
            bucket_index_reg <= bucket_index_next;
            minor_total_reg  <= minor_total_next;
            major_total_reg  <= major_total_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign bucket_index = bucket_index_reg;
    assign minor_total  = minor_total_reg;
    assign major_total  = major_total_reg;

endmodule

/* hdl/lhc_classify.sv */
// Duration to bucket classifier: parallel compares against the bucket bounds.
// Depends on lhc_pkg.
module lhc_classify
    import lhc_pkg::*;
(
    input  logic [DUR_W-1:0]    latency_ns,
    output logic [BUCKET_W-1:0] bucket
);

    logic [NUM_BOUNDS-1:0] at_or_above;
    logic                  negative;
    logic                  huge;

    // bucket index counts the bounds at or below a non-negative duration
    always_comb
    begin
        negative = latency_ns[DUR_W-1];
        huge     = |latency_ns[DUR_W-2:BOUND_W];
        for (int i = 0; i < NUM_BOUNDS; i++)
        begin
            at_or_above[i] = latency_ns[BOUND_W-1:0] >= BOUNDS[i];
        end
        if (negative)
        begin
            bucket = '0;
        end
        else if (huge)
        begin
            bucket = LAST_BUCKET;
        end
        else
        begin
            bucket = BUCKET_W'($countones(at_or_above));
        end
    end

endmodule

/* hdl/lhc_counters.sv */
// Minor and major counter banks with increment, read and clear.
// Depends on lhc_pkg; driven by the top level's command struct.
module lhc_counters
    import lhc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lhc_cmd_t               cmd,
    output logic [BUCKET_W-1:0]    bucket_index,
    output logic [COUNT_WIDTH-1:0] minor_total,
    output logic [COUNT_WIDTH-1:0] major_total
);

    logic [COUNT_WIDTH-1:0] minor_reg [BUCKET_COUNT];
    logic [COUNT_WIDTH-1:0] major_reg [BUCKET_COUNT];
    logic [COUNT_WIDTH-1:0] minor_next;
    logic [COUNT_WIDTH-1:0] major_next;
    logic                   inc_minor;
    logic                   inc_major;
    logic                   do_clear;

    always_comb
    begin
        inc_minor    = 1'b0;
        inc_major    = 1'b0;
        do_clear     = 1'b0;
        minor_next   = minor_reg[cmd.bucket];
        major_next   = major_reg[cmd.bucket];
        bucket_index = '0;
        minor_total  = '0;
        major_total  = '0;
        case (cmd.func)
            FUNC_RECORD:
            begin
                inc_minor = cmd.fire && !cmd.major;
                inc_major = cmd.fire && cmd.major;
                if (cmd.major)
                begin
                    major_next = major_reg[cmd.bucket] + COUNT_WIDTH'(1);
                end
                else
                begin
                    minor_next = minor_reg[cmd.bucket] + COUNT_WIDTH'(1);
                end
                bucket_index = cmd.bucket;
                minor_total  = minor_next;
                major_total  = major_next;
            end
            FUNC_READ:
            begin
                bucket_index = cmd.bucket;
                minor_total  = minor_next;
                major_total  = major_next;
            end
            FUNC_CLEAR:
            begin
                do_clear = cmd.fire;
            end
            default:
            begin
                do_clear = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUCKET_COUNT; i++)
            begin
                minor_reg[i] <= '0;
                major_reg[i] <= '0;
            end
        end
        else if (do_clear)
        begin
            for (int i = 0; i < BUCKET_COUNT; i++)
            begin
                minor_reg[i] <= '0;
                major_reg[i] <= '0;
            end
        end
        else
        begin
            if (inc_minor)
            begin
                minor_reg[cmd.bucket] <= minor_next;
            end
            if (inc_major)
            begin
                major_reg[cmd.bucket] <= major_next;
            end
        end
    end

endmodule
